// File: design/sglg_pkg.sv
// Shared types, constants and the 5x7 font lookup for the glyph line generator.
// No dependencies; every design file imports this package.
package sglg_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 320;
  localparam int MAX_SCALE     = 8;
  localparam int GLYPH_ROWS    = 7;
  localparam int GLYPH_COLS    = 5;
  localparam int MASK_W        = 40;
  localparam int CW            = 13;

  typedef logic [3:0] scale_t;

  typedef struct packed {
    logic [7:0]         char_code;
    logic signed [11:0] origin_x;
    logic signed [11:0] origin_y;
  } in_t;

  typedef struct packed {
    logic [7:0]        win_x0;
    logic [8:0]        win_y0;
    logic [7:0]        win_x1;
    logic [8:0]        win_y1;
    logic [5:0]        line_index;
    logic [MASK_W-1:0] pixel_mask;
    logic              last_line;
  } out_t;

  typedef struct packed {
    logic              hit;
    logic [6:0][4:0]   rows;
  } glyph_t;

  typedef struct packed {
    logic load;
    logic step;
    logic col_on;
  } ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BUILD,
    ST_EMIT
  } state_t;

  function automatic glyph_t mk(input logic [4:0] r0, input logic [4:0] r1,
                                input logic [4:0] r2, input logic [4:0] r3,
                                input logic [4:0] r4, input logic [4:0] r5,
                                input logic [4:0] r6);
    glyph_t g;
    g.hit     = 1'b1;
    g.rows[0] = r0;
    g.rows[1] = r1;
    g.rows[2] = r2;
    g.rows[3] = r3;
    g.rows[4] = r4;
    g.rows[5] = r5;
    g.rows[6] = r6;
    return g;
  endfunction

  function automatic glyph_t font_lookup(input logic [7:0] code);
    glyph_t g;
    g = '0;
    case (code)
      8'h41: g = mk(5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
      8'h42: g = mk(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E);
      8'h43: g = mk(5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E);
      8'h44: g = mk(5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C);
      8'h45: g = mk(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F);
      8'h46: g = mk(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10);
      8'h47: g = mk(5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F);
      8'h48: g = mk(5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
      8'h49: g = mk(5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F);
      8'h4A: g = mk(5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C);
      8'h4B: g = mk(5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11);
      8'h4C: g = mk(5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F);
      8'h4D: g = mk(5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11);
      8'h4E: g = mk(5'h11, 5'h19, 5'h15, 5'h15, 5'h13, 5'h11, 5'h11);
      8'h4F: g = mk(5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
      8'h50: g = mk(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10);
      8'h51: g = mk(5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D);
      8'h52: g = mk(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11);
      8'h53: g = mk(5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E);
      8'h54: g = mk(5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04);
      8'h55: g = mk(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
      8'h56: g = mk(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04);
      8'h57: g = mk(5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A);
      8'h58: g = mk(5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11);
      8'h59: g = mk(5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04);
      8'h5A: g = mk(5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F);
      8'h30: g = mk(5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E);
      8'h31: g = mk(5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E);
      8'h32: g = mk(5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F);
      8'h33: g = mk(5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E);
      8'h34: g = mk(5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02);
      8'h35: g = mk(5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E);
      8'h36: g = mk(5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E);
      8'h37: g = mk(5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08);
      8'h38: g = mk(5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E);
      8'h39: g = mk(5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C);
      8'h21: g = mk(5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// File: design/sglg_expand.sv
// Row mask builder: a shared shifter, one column per cycle while stepping.
// Depends on sglg_pkg for mask width and the control struct.
module sglg_expand import sglg_pkg::*; (
  input  logic              clk,
  input  ctl_t              ctl,
  input  scale_t            scale,
  output logic [MASK_W-1:0] mask
);

  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic [MASK_W-1:0] seg_r, seg_nxt;

  always_comb begin
    mask_nxt = mask_r;
    seg_nxt  = seg_r;
    if (ctl.load) begin
      mask_nxt = '0;
      seg_nxt  = ~({MASK_W{1'b1}} >> scale);
    end else if (ctl.step) begin
      if (ctl.col_on) begin
        mask_nxt = mask_r | seg_r;
      end
      seg_nxt = seg_r >> scale;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    seg_r  <= seg_nxt;
  end

  assign mask = mask_r;

endmodule

// File: design/sglg_ctrl.sv
// Sequencer: scale register, glyph lookup, bounds check, row/line counters, output register.
// Depends on sglg_pkg; drives sglg_expand through a ctl_t struct.
module sglg_ctrl import sglg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_data,
  input  logic [MASK_W-1:0] row_mask,
  output ctl_t              ctl,
  output scale_t            scale
);

  state_t state_r, state_nxt;
  scale_t scale_r;
  in_t    in_r;
  glyph_t glyph_r;
  logic [2:0] row_r, rep_r, col_r;
  logic [5:0] line_r;
  logic [7:0] win_x0_r, win_x1_r;
  logic [8:0] win_y0_r, win_y1_r;
  logic       out_valid_r;
  out_t       out_data_r;

  logic [CW-1:0] x_ext, y_ext, w_ext, h_ext, x_end, y_end;
  logic          fits;
  logic          emit_fire;
  logic          rep_done;
  logic          row_last;
  logic [4:0]    cur_row;

  assign x_ext = {1'b0, in_r.origin_x};
  assign y_ext = {1'b0, in_r.origin_y};
  assign w_ext = CW'(scale_r) * CW'(GLYPH_COLS);
  assign h_ext = CW'(scale_r) * CW'(GLYPH_ROWS);
  assign x_end = x_ext + w_ext;
  assign y_end = y_ext + h_ext;
  assign fits  = !in_r.origin_x[11] && !in_r.origin_y[11] &&
                 (x_end <= CW'(SCREEN_WIDTH)) && (y_end <= CW'(SCREEN_HEIGHT));

  assign cur_row   = glyph_r.rows[row_r];
  assign rep_done  = (4'(rep_r) + 4'd1) == scale_r;
  assign row_last  = row_r == 3'(GLYPH_ROWS - 1);
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = (glyph_r.hit && fits) ? ST_BUILD : ST_IDLE;
      end
      ST_BUILD: begin
        if (col_r == 3'(GLYPH_COLS - 1)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_fire && rep_done) state_nxt = row_last ? ST_IDLE : ST_BUILD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ctl.load   = 1'b0;
    ctl.step   = 1'b0;
    ctl.col_on = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_CHECK: begin
        ctl.load = 1'b1;
      end
      ST_BUILD: begin
        ctl.step   = 1'b1;
        ctl.col_on = cur_row[3'(GLYPH_COLS - 1) - col_r];
      end
      ST_EMIT: begin
        ctl.load = emit_fire && rep_done && !row_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scale_r     <= 4'd1;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      rep_r       <= '0;
      col_r       <= '0;
      line_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_data == '0) begin
          scale_r <= 4'd1;
        end else if (cfg_data > 4'(MAX_SCALE)) begin
          scale_r <= 4'(MAX_SCALE);
        end else begin
          scale_r <= cfg_data;
        end
      end
      case (state_r)
        ST_CHECK: begin
          row_r  <= '0;
          rep_r  <= '0;
          col_r  <= '0;
          line_r <= '0;
        end
        ST_BUILD: begin
          col_r <= col_r + 3'd1;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            line_r <= line_r + 6'd1;
            if (rep_done) begin
              rep_r <= '0;
              col_r <= '0;
              row_r <= row_r + 3'd1;
            end else begin
              rep_r <= rep_r + 3'd1;
            end
          end
        end
        default: begin
          col_r <= col_r;
        end
      endcase
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r    <= in_data;
      glyph_r <= font_lookup(in_data.char_code);
    end
    if (state_r == ST_CHECK) begin
      win_x0_r <= x_ext[7:0];
      win_y0_r <= y_ext[8:0];
      win_x1_r <= 8'(x_end - CW'(1));
      win_y1_r <= 9'(y_end - CW'(1));
    end
    if (emit_fire) begin
      out_data_r.win_x0     <= win_x0_r;
      out_data_r.win_y0     <= win_y0_r;
      out_data_r.win_x1     <= win_x1_r;
      out_data_r.win_y1     <= win_y1_r;
      out_data_r.line_index <= line_r;
      out_data_r.pixel_mask <= row_mask;
      out_data_r.last_line  <= rep_done && row_last;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign scale     = scale_r;

`ifndef SYNTHESIS
  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    (scale_r >= 4'd1) && (scale_r <= 4'(MAX_SCALE)))
    else $error("scale register out of range");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && rep_done && row_last) |=> (state_r == ST_IDLE))
    else $error("sequencer did not finish after last line");

  a_line_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |->
      (7'(line_r) == 7'(row_r) * 7'(scale_r) + 7'(rep_r)))
    else $error("line counter out of step with row and repeat counters");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUILD) |-> (col_r < 3'(GLYPH_COLS)))
    else $error("column counter overran glyph width");
`endif

endmodule

// File: design/scaled_glyph_line_generator_top.sv
// Top level of the scaled 5x7 glyph line generator.
// Depends on sglg_pkg, sglg_ctrl and sglg_expand.
//
// Input channel (in_valid/in_ready/in_data) takes a character code and origin.
// Result channel (out_valid/out_ready/out_data) delivers 7*scale line
// transactions, top first, last one flagged by last_line. A space, an unknown
// code or a glyph that does not fit on screen yields no result.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes the scale register,
// saturated to 1..8; cfg_ready is always high. Write only while idle.
// Sequence: the accepting cycle looks the glyph up, the CHECK state checks
// bounds. Each glyph row is then built in the shared column shifter, one
// column per cycle, followed by scale line transactions at one per cycle
// while the receiver is ready. A rejected glyph goes back to idle from CHECK.
// in_ready is high only while idle. When the receiver stalls, the held line
// stays in the output register and the sequencer waits.
// Reset (rst_n low, synchronous) returns to idle, sets scale to 1 and drops
// out_valid.
module scaled_glyph_line_generator_top import sglg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  ctl_t              ctl;
  scale_t            scale;
  logic [MASK_W-1:0] row_mask;

  sglg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .row_mask  (row_mask),
    .ctl       (ctl),
    .scale     (scale)
  );

  sglg_expand u_expand (
    .clk   (clk),
    .ctl   (ctl),
    .scale (scale),
    .mask  (row_mask)
  );

endmodule

// File: sim/tb_scaled_glyph_line_generator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for scaled_glyph_line_generator_top: directed and random
// characters, predicted line transactions compared in order. Depends on sglg_pkg.
module tb_scaled_glyph_line_generator_top;
  import sglg_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 12;
  localparam int CHARS_PER_PHASE = 33;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [3:0] cfg_data;

  logic [34:0] font_rows [256];
  bit font_known [256];

  in_t pending_chars [$];
  out_t expected_lines [$];
  int chars_queued;
  int chars_accepted;
  int fail_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int scale_shadow;
  bit in_taken;

  scaled_glyph_line_generator_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic add_glyph(input logic [7:0] code, input logic [34:0] rows);
    font_rows[code] = rows;
    font_known[code] = 1'b1;
  endtask

  function automatic void predict_glyph_lines(input in_t item);
    int x;
    int y;
    int w;
    int h;
    int line_no;
    logic [4:0] bits;
    logic [39:0] mask;
    logic [31:0] x1;
    logic [31:0] y1;
    out_t line;
    if (!font_known[item.char_code]) return;
    x = $signed(item.origin_x);
    y = $signed(item.origin_y);
    w = GLYPH_COLS * scale_shadow;
    h = GLYPH_ROWS * scale_shadow;
    if (x < 0 || y < 0 || x + w > SCREEN_WIDTH || y + h > SCREEN_HEIGHT) return;
    x1 = x + w - 1;
    y1 = y + h - 1;
    line_no = 0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      bits = font_rows[item.char_code][34 - 5 * r -: 5];
      mask = '0;
      for (int c = 0; c < GLYPH_COLS; c++) begin
        if (bits[4 - c]) begin
          for (int k = 0; k < scale_shadow; k++) mask[39 - (c * scale_shadow + k)] = 1'b1;
        end
      end
      for (int rep = 0; rep < scale_shadow; rep++) begin
        line.win_x0 = x[7:0];
        line.win_y0 = y[8:0];
        line.win_x1 = x1[7:0];
        line.win_y1 = y1[8:0];
        line.line_index = line_no[5:0];
        line.pixel_mask = mask;
        line.last_line = (line_no == h - 1);
        expected_lines.push_back(line);
        line_no++;
      end
    end
  endfunction

  function automatic in_t make_random_char();
    in_t it;
    int w;
    int h;
    int kind;
    w = GLYPH_COLS * scale_shadow;
    h = GLYPH_ROWS * scale_shadow;
    kind = $urandom_range(99);
    do it.char_code = 8'($urandom_range(33, 90)); while (!font_known[it.char_code]);
    it.origin_x = 12'($urandom_range(SCREEN_WIDTH - w, 0));
    it.origin_y = 12'($urandom_range(SCREEN_HEIGHT - h, 0));
    if (kind >= 90) begin
      it = $urandom;
    end else if (kind >= 86) begin
      it.origin_x = 12'(SCREEN_WIDTH - w + 1 + $urandom_range(3, 0));
    end else if (kind >= 82) begin
      it.origin_y = 12'(SCREEN_HEIGHT - h + 1 + $urandom_range(3, 0));
    end else if (kind >= 79) begin
      it.origin_x = 12'(-1 - $urandom_range(7, 0));
    end else if (kind >= 76) begin
      it.origin_y = 12'(-1 - $urandom_range(7, 0));
    end else if (kind >= 72) begin
      it.char_code = 8'($urandom_range(255, 0));
    end
    return it;
  endfunction

  task automatic queue_char(input logic [7:0] code, input int x, input int y);
    in_t it;
    it.char_code = code;
    it.origin_x = 12'(x);
    it.origin_y = 12'(y);
    pending_chars.push_back(it);
    chars_queued++;
  endtask

  task automatic wait_for_idle();
    while (chars_accepted != chars_queued || expected_lines.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_scale(input logic [3:0] raw);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= raw;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [39:0] want, input logic [39:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_chars.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : monitor
    out_t want;
    in_taken = rst_n && in_valid && in_ready;
    if (!rst_n) begin
      scale_shadow = 1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data == 0) scale_shadow = 1;
      else if (cfg_data > MAX_SCALE) scale_shadow = MAX_SCALE;
      else scale_shadow = int'(cfg_data);
    end
    if (in_taken) begin
      predict_glyph_lines(in_data);
      chars_accepted++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        $error("line transaction with none expected: %0h", out_data);
        fail_count++;
      end else begin
        want = expected_lines.pop_front();
        check_field("win_x0", 40'(want.win_x0), 40'(out_data.win_x0));
        check_field("win_y0", 40'(want.win_y0), 40'(out_data.win_y0));
        check_field("win_x1", 40'(want.win_x1), 40'(out_data.win_x1));
        check_field("win_y1", 40'(want.win_y1), 40'(out_data.win_y1));
        check_field("line_index", 40'(want.line_index), 40'(out_data.line_index));
        check_field("pixel_mask", want.pixel_mask, out_data.pixel_mask);
        check_field("last_line", 40'(want.last_line), 40'(out_data.last_line));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_taken = 1'b0;
    scale_shadow = 1;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_glyph("A", {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11});
    add_glyph("B", {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E});
    add_glyph("C", {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E});
    add_glyph("D", {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C});
    add_glyph("E", {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F});
    add_glyph("F", {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10});
    add_glyph("G", {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F});
    add_glyph("H", {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11});
    add_glyph("I", {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F});
    add_glyph("J", {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C});
    add_glyph("K", {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11});
    add_glyph("L", {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F});
    add_glyph("M", {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11});
    add_glyph("N", {5'h11, 5'h19, 5'h15, 5'h15, 5'h13, 5'h11, 5'h11});
    add_glyph("O", {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E});
    add_glyph("P", {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10});
    add_glyph("Q", {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D});
    add_glyph("R", {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11});
    add_glyph("S", {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E});
    add_glyph("T", {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04});
    add_glyph("U", {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E});
    add_glyph("V", {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04});
    add_glyph("W", {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A});
    add_glyph("X", {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11});
    add_glyph("Y", {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04});
    add_glyph("Z", {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F});
    add_glyph("0", {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E});
    add_glyph("1", {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E});
    add_glyph("2", {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F});
    add_glyph("3", {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E});
    add_glyph("4", {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02});
    add_glyph("5", {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E});
    add_glyph("6", {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E});
    add_glyph("7", {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08});
    add_glyph("8", {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E});
    add_glyph("9", {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C});
    add_glyph("!", {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // scale 1 straight out of reset: corners, blanks, unknown codes, off-screen origins
    queue_char("A", 0, 0);
    queue_char("!", SCREEN_WIDTH - 5, SCREEN_HEIGHT - 7);
    queue_char("0", 100, 50);
    queue_char(" ", 10, 10);
    queue_char(8'hFF, 10, 10);
    queue_char(8'h80, 10, 10);
    queue_char("B", -1, 0);
    queue_char("C", 0, -2048);
    queue_char("D", SCREEN_WIDTH - 4, 0);
    queue_char("E", 0, SCREEN_HEIGHT - 6);
    queue_char("Z", 2047, 2047);
    wait_for_idle();

    write_scale(4'd0);
    queue_char("H", 0, SCREEN_HEIGHT - 7);
    wait_for_idle();

    write_scale(4'd15);
    queue_char("W", SCREEN_WIDTH - 40, SCREEN_HEIGHT - 56);
    queue_char("M", SCREEN_WIDTH - 39, 0);
    queue_char("Q", 0, SCREEN_HEIGHT - 55);
    queue_char("8", 0, 0);
    wait_for_idle();

    write_scale(4'd8);
    queue_char("9", 100, 100);
    wait_for_idle();

    write_scale(4'd2);
    queue_char("J", SCREEN_WIDTH - 10, 0);
    queue_char("a", 0, 0);
    queue_char(8'h00, 0, 0);
    wait_for_idle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase / 4)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0: write_scale(4'd0);
        1: write_scale(4'd15);
        2: write_scale(4'd8);
        3: write_scale(4'd1);
        default: write_scale(4'($urandom_range(15, 0)));
      endcase
      for (int n = 0; n < CHARS_PER_PHASE; n++) begin
        it = make_random_char();
        queue_char(it.char_code, int'(it.origin_x), int'(it.origin_y));
      end
      wait_for_idle();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
